// ===== hdl/gtcm_pkg.sv =====
// ----------------------------------------------------------------------------
// gtcm_pkg
// Types and constants shared by the gray to color transfer map block.
// ----------------------------------------------------------------------------
`default_nettype none

package gtcm_pkg;

  // sample and channel format
  localparam int SAMPLE_BITS = 16;
  localparam int Q_W         = SAMPLE_BITS + 1;  // normalized value, 0 .. 1.0
  localparam int CHAN_W      = 16;
  localparam int CHANNELS    = 4;

  typedef logic [CHANNELS-1:0][CHAN_W-1:0] chan_t;  // [0] red .. [3] alpha

  localparam logic [CHAN_W-1:0] OUT_MAX = {CHAN_W{1'b1}};

  // stream payload layout
  localparam int OP_W        = 2;
  localparam int ENTRY_IDX_W = 8;
  localparam int IN_DATA_W   = ENTRY_IDX_W + CHANNELS * CHAN_W + SAMPLE_BITS;
  localparam int IN_USER_W   = OP_W + 1;
  localparam int OUT_DATA_W  = CHANNELS * CHAN_W;

  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_ACCUM  = 2'd1;
  localparam logic [OP_W-1:0] OP_MAP    = 2'd2;

  // configuration registers
  localparam int TE_W       = 9;
  localparam int CC_W       = 3;
  localparam int CFG_DATA_W = 9;
  localparam int REG_IDX_W  = 1;

  localparam logic [REG_IDX_W-1:0] REG_TABLE_ENTRIES = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b1;

  localparam logic [TE_W-1:0] TE_RESET       = 9'd0;
  localparam logic [CC_W-1:0] CC_RESET       = 3'd3;
  localparam logic [CC_W-1:0] ALPHA_CHANNELS = 3'd4;

  // a span at or below this many lsb counts as an empty range
  localparam int SPAN_MIN = (1 << SAMPLE_BITS) / 10000;

  // gray ramp: (10 t + 3.0) / 13, the division done by a reciprocal
  localparam int RAMP_X_W    = 20;
  localparam int RECIP_W     = 21;
  localparam int RAMP_P_W    = RAMP_X_W + RECIP_W;
  localparam int RECIP_SHIFT = 24;
  localparam logic [RAMP_X_W-1:0] RAMP_BIAS = RAMP_X_W'(3 << SAMPLE_BITS);
  localparam logic [RECIP_W-1:0]  RECIP_13  = RECIP_W'(((1 << RECIP_SHIFT) + 12) / 13);

  // iterative divider
  localparam int DIV_CNT_W = $clog2(Q_W + 1);

  typedef struct packed {
    logic                   start;
    logic [SAMPLE_BITS-1:0] num;   // never above den
    logic [SAMPLE_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] quot;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== hdl/gtcm_table.sv =====
// ----------------------------------------------------------------------------
// gtcm_table
// Transfer table memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module gtcm_table #(
  parameter  int DEPTH = 256,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  gtcm_pkg::chan_t wdata_i,
  input  logic            re_i,
  input  logic [AW-1:0]   raddr_a_i,
  input  logic [AW-1:0]   raddr_b_i,
  output gtcm_pkg::chan_t rdata_a_o,
  output gtcm_pkg::chan_t rdata_b_o
);
  import gtcm_pkg::*;

  chan_t mem_q [DEPTH];
  chan_t rd_a_q;
  chan_t rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rd_a_q <= mem_q[raddr_a_i];
      rd_b_q <= mem_q[raddr_b_i];
    end
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

`default_nettype wire

// ===== hdl/gtcm_div.sv =====
// ----------------------------------------------------------------------------
// gtcm_div
// Radix-2 restoring divider for num / den with num <= den, one quotient bit
// per cycle, giving floor(num * 2^16 / den).
// ----------------------------------------------------------------------------
`default_nettype none

module gtcm_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gtcm_pkg::div_req_t req_i,
  output gtcm_pkg::div_rsp_t rsp_o
);
  import gtcm_pkg::*;

  logic                   busy_q;
  logic                   done_q;
  logic [DIV_CNT_W-1:0]   cnt_q;
  logic [Q_W-1:0]         rem_q;
  logic [SAMPLE_BITS-1:0] den_q;
  logic [Q_W-1:0]         quot_q;

  logic                   ge;
  logic [Q_W-1:0]         rem_sub;

  assign ge      = rem_q >= {1'b0, den_q};
  assign rem_sub = ge ? rem_q - {1'b0, den_q} : rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_CNT_W'(Q_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - DIV_CNT_W'(1);
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q  <= {1'b0, req_i.num};
      den_q  <= req_i.den;
      quot_q <= '0;
    end else if (busy_q) begin
      // remainder after subtract is below den, so the shift cannot overflow
      rem_q  <= {rem_sub[SAMPLE_BITS-1:0], 1'b0};
      quot_q <= {quot_q[Q_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;

endmodule

`default_nettype wire

// ===== hdl/gray_to_color_transfer_map.sv =====
// ----------------------------------------------------------------------------
// gray_to_color_transfer_map
// Maps gray samples to RGBA colors through a transfer table or a gray ramp.
// ----------------------------------------------------------------------------
// A table write or a range accumulate completes on acceptance, and the block
// stays idle. A map transaction goes through the table or through the gray
// ramp, and skips the divider when the accumulated range is empty or narrow.
// A map first normalizes the sample in the 17-step serial divider; the table
// path then makes two reads of the table memory and one multiply per channel
// for the interpolation. The input side takes the next transaction as soon as
// a map has finished, while its color still waits in the output register. The
// table is not cleared at reset; reading an entry that was never written gives
// an undefined color.
`default_nettype none

module gray_to_color_transfer_map #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // s_axis_tdata: entry_index, entry_red, entry_green, entry_blue,
  //               entry_alpha, gray_sample
  // s_axis_tuser: operation, restart_range
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  input  logic [gtcm_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  input  logic [gtcm_pkg::IN_USER_W-1:0]       s_axis_tuser,
  // m_axis_tdata: out_red, out_green, out_blue, out_alpha
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  output logic [gtcm_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gtcm_pkg::REG_IDX_W-1:0]       cfg_index_i,
  input  logic [gtcm_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import gtcm_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = (AW + 1 > TE_W) ? AW + 1 : TE_W;
  localparam int PW = AW + Q_W;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_POST  = 3'd2;
  localparam logic [2:0] ST_RAMP  = 3'd3;
  localparam logic [2:0] ST_ADDR  = 3'd4;
  localparam logic [2:0] ST_BLEND = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  localparam logic [2:0] K_LAST = 3'(CHANNELS);

  // input fields
  logic [OP_W-1:0]        in_op;
  logic                   in_restart;
  logic [ENTRY_IDX_W-1:0] in_idx;
  chan_t                  in_entry;
  logic [SAMPLE_BITS-1:0] in_sample;

  assign in_op      = s_axis_tuser[OP_W-1:0];
  assign in_restart = s_axis_tuser[OP_W];
  assign in_idx     = s_axis_tdata[ENTRY_IDX_W-1:0];
  assign in_entry   = s_axis_tdata[ENTRY_IDX_W +: OUT_DATA_W];
  assign in_sample  = s_axis_tdata[ENTRY_IDX_W + OUT_DATA_W +: SAMPLE_BITS];

  // registers
  logic [2:0]             state_q;
  logic [TE_W-1:0]        table_entries_q;
  logic [CC_W-1:0]        channel_count_q;
  logic [SAMPLE_BITS-1:0] range_low_q;
  logic [SAMPLE_BITS-1:0] range_high_q;
  logic                   out_valid_q;
  logic [2:0]             k_q;
  logic [Q_W-1:0]         t_q;
  logic [AW-1:0]          lo_q;
  logic [SAMPLE_BITS-1:0] tail_q;
  logic [RAMP_P_W-1:0]    ramp_q;
  logic signed [33:0]     prod_q;
  chan_t                  res_q;
  chan_t                  out_q;

  logic accept;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign cfg_ready_o   = 1'b1;

  // range check and clamp of the sample
  logic [SAMPLE_BITS-1:0] span;
  logic                   narrow;
  logic [SAMPLE_BITS-1:0] clamped;

  assign span    = range_high_q - range_low_q;
  assign narrow  = (range_high_q < range_low_q) || (span <= SAMPLE_BITS'(SPAN_MIN));
  assign clamped = (in_sample < range_low_q)  ? range_low_q :
                   (in_sample > range_high_q) ? range_high_q : in_sample;

  div_req_t div_req;
  div_rsp_t div_rsp;

  assign div_req.start = accept && (in_op == OP_MAP) && !narrow;
  assign div_req.num   = clamped - range_low_q;
  assign div_req.den   = span;

  gtcm_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // effective table length
  logic [CW-1:0] n_eff;
  logic          tbl_empty;
  logic [AW-1:0] nm1;

  assign n_eff     = (CW'(table_entries_q) > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                               : CW'(table_entries_q);
  assign tbl_empty = (table_entries_q == '0);
  assign nm1       = AW'(n_eff - CW'(1));

  // table position and interpolation weight
  logic [PW-1:0] pos;
  logic [AW:0]   lo_full;
  logic [AW-1:0] lo_c;
  logic [AW-1:0] hi_c;

  assign pos     = PW'(nm1) * PW'(t_q);
  assign lo_full = pos[PW-1:SAMPLE_BITS];
  assign lo_c    = (lo_full > {1'b0, nm1}) ? nm1 : lo_full[AW-1:0];
  assign hi_c    = (lo_q == nm1) ? nm1 : lo_q + AW'(1);

  // table memory
  logic  tbl_we;
  chan_t rd_a;
  chan_t rd_b;

  assign tbl_we = accept && (in_op == OP_WRITE) && (CW'(in_idx) < CW'(TABLE_DEPTH));

  gtcm_table #(
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .we_i      (tbl_we),
    .waddr_i   (AW'(in_idx)),
    .wdata_i   (in_entry),
    .re_i      (state_q == ST_ADDR),
    .raddr_a_i (lo_q),
    .raddr_b_i (hi_c),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  // gray ramp
  logic [RAMP_X_W-1:0] ramp_x;
  logic [Q_W-1:0]      ramp_g_full;
  logic [CHAN_W-1:0]   ramp_g;

  assign ramp_x      = (RAMP_X_W'(t_q) << 3) + (RAMP_X_W'(t_q) << 1) + RAMP_BIAS;
  assign ramp_g_full = ramp_q[RECIP_SHIFT +: Q_W];
  assign ramp_g      = (ramp_g_full > Q_W'(OUT_MAX)) ? OUT_MAX : ramp_g_full[CHAN_W-1:0];

  // a + (b - a) * tail / 2^16, floor taken on the signed product
  logic [1:0]         ch_k;
  logic [1:0]         ch_prev;
  logic signed [16:0] blend_diff;
  logic signed [16:0] tail_s;
  logic signed [33:0] blend_mul;
  logic signed [33:0] blend_sum;

  assign ch_k       = k_q[1:0];
  assign ch_prev    = k_q[1:0] - 2'd1;
  assign blend_diff = $signed({1'b0, rd_b[ch_k]}) - $signed({1'b0, rd_a[ch_k]});
  assign tail_s     = $signed({1'b0, tail_q});
  assign blend_mul  = blend_diff * tail_s;
  assign blend_sum  = $signed({18'b0, rd_a[ch_prev]}) + (prod_q >>> SAMPLE_BITS);

  logic out_free;
  logic out_valid_d;
  assign out_free    = !out_valid_q || m_axis_tready;
  assign out_valid_d = ((state_q == ST_FIN) && out_free) || (out_valid_q && !m_axis_tready);

  // control state, configuration and range
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= ST_IDLE;
      table_entries_q <= TE_RESET;
      channel_count_q <= CC_RESET;
      range_low_q     <= {SAMPLE_BITS{1'b1}};
      range_high_q    <= '0;
      out_valid_q     <= 1'b0;
      k_q             <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_TABLE_ENTRIES: table_entries_q <= cfg_data_i[TE_W-1:0];
          REG_CHANNEL_COUNT: channel_count_q <= cfg_data_i[CC_W-1:0];
          default: ;
        endcase
      end

      out_valid_q <= out_valid_d;

      case (state_q)
        ST_IDLE: begin
          if (accept && (in_op == OP_ACCUM)) begin
            if (in_restart) begin
              range_low_q  <= in_sample;
              range_high_q <= in_sample;
            end else begin
              if (in_sample < range_low_q) begin
                range_low_q <= in_sample;
              end
              if (in_sample > range_high_q) begin
                range_high_q <= in_sample;
              end
            end
          end
          if (accept && (in_op == OP_MAP)) begin
            state_q <= narrow ? ST_POST : ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_rsp.done) begin
            state_q <= ST_POST;
          end
        end
        ST_POST: begin
          state_q <= tbl_empty ? ST_RAMP : ST_ADDR;
        end
        ST_RAMP: begin
          state_q <= ST_FIN;
        end
        ST_ADDR: begin
          k_q     <= '0;
          state_q <= ST_BLEND;
        end
        ST_BLEND: begin
          if (k_q == K_LAST) begin
            state_q <= ST_FIN;
          end else begin
            k_q <= k_q + 3'd1;
          end
        end
        ST_FIN: begin
          if (out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_op == OP_MAP) && narrow) begin
          t_q <= '0;
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          t_q <= div_rsp.quot;
        end
      end
      ST_POST: begin
        ramp_q <= {{RECIP_W{1'b0}}, ramp_x} * {{RAMP_X_W{1'b0}}, RECIP_13};
        lo_q   <= lo_c;
        tail_q <= pos[SAMPLE_BITS-1:0];
      end
      ST_RAMP: begin
        res_q <= {OUT_MAX, ramp_g, ramp_g, ramp_g};
      end
      ST_BLEND: begin
        if (k_q != K_LAST) begin
          prod_q <= blend_mul;
        end
        if (k_q != 3'd0) begin
          res_q[ch_prev] <= blend_sum[CHAN_W-1:0];
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_q <= {((channel_count_q == ALPHA_CHANNELS) ? res_q[3] : {CHAN_W{1'b0}}),
                    res_q[2:0]};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTH
  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> state_q == ST_DIV)
    else $error("divider finished outside the divide state");

  a_map_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (in_op == OP_MAP)) |=> state_q != ST_IDLE)
    else $error("map transaction did not start work");

  a_lo_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADDR) |-> (lo_q <= nm1))
    else $error("lower table index beyond last entry");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("output loaded outside the finish state");

  a_blend_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_BLEND) |-> (k_q <= K_LAST))
    else $error("blend channel counter out of range");
`endif

endmodule

`default_nettype wire
